FILE: sv/qtr_pkg.sv
// shared constants and types for the quarter-turn rotate address generator
`default_nettype none

package qtr_pkg;

   // largest source dimension, rows or cols
   localparam int MAX_DIM    = 4096;

   localparam int PIXEL_W    = 24;
   localparam int INDEX_W    = 24;
   localparam int DIM_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int MODE_W     = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_MODE = 2'd2;

   // turn modes
   localparam logic [MODE_W-1:0] TURN_NONE = 2'd0;
   localparam logic [MODE_W-1:0] TURN_90   = 2'd1;
   localparam logic [MODE_W-1:0] TURN_180  = 2'd2;
   localparam logic [MODE_W-1:0] TURN_270  = 2'd3;

   // per-beat fields that pass straight from front to back
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic               last;
   } info_type;

endpackage

`default_nettype wire

FILE: sv/qtr_if.sv
// valid/ready channel interfaces for source pixels and rotated results
`default_nettype none

interface qtr_req_if;
   logic                         valid;
   logic                         ready;
   logic [qtr_pkg::PIXEL_W-1:0]  src_pixel;

   modport source (output valid, output src_pixel, input ready);
   modport sink   (input valid, input src_pixel, output ready);
endinterface

interface qtr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [qtr_pkg::PIXEL_W-1:0]  dst_pixel;
   logic [qtr_pkg::INDEX_W-1:0]  dst_index;
   logic [qtr_pkg::DIM_W-1:0]    dst_rows;
   logic [qtr_pkg::DIM_W-1:0]    dst_cols;
   logic                         frame_last;

   modport source (output valid, output dst_pixel, output dst_index, output dst_rows,
                   output dst_cols, output frame_last, input ready);
   modport sink   (input valid, input dst_pixel, input dst_index, input dst_rows,
                   input dst_cols, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: sv/qtr_front.sv
// front end: config registers, raster counters and index operand selection
`default_nettype none

module qtr_front #(
   parameter int CW      = 12,
   parameter int DW      = 13
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [qtr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [qtr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                              push,
   input  wire [qtr_pkg::PIXEL_W-1:0]       src_pixel,
   output qtr_pkg::info_type                info,
   output logic [CW-1:0]                    op_a,
   output logic [DW-1:0]                    op_m,
   output logic [CW-1:0]                    op_b
);

   logic [qtr_pkg::DIM_W-1:0]  rows_ff;
   logic [qtr_pkg::DIM_W-1:0]  cols_ff;
   logic [qtr_pkg::MODE_W-1:0] mode_ff;
   logic [CW-1:0]              row_ff, row_in;
   logic [CW-1:0]              col_ff, col_in;

   logic [DW-1:0] eff_r, eff_c;
   logic [CW-1:0] r_eff, c_eff;
   logic [DW-1:0] r_rev_w, c_rev_w;
   logic [CW-1:0] r_rev, c_rev;
   logic          last_r, last_c;

   function automatic logic [DW-1:0] eff_dim(input logic [qtr_pkg::DIM_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) return DW'(1);
      if (v32 > 32'(qtr_pkg::MAX_DIM)) return DW'(qtr_pkg::MAX_DIM);
      return DW'(v32);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= qtr_pkg::DIM_W'(1);
         cols_ff <= qtr_pkg::DIM_W'(1);
         mode_ff <= qtr_pkg::TURN_NONE;
      end else if (csr_we) begin
         unique case (csr_index)
            qtr_pkg::CSR_SRC_ROWS:  rows_ff <= csr_wdata;
            qtr_pkg::CSR_SRC_COLS:  cols_ff <= csr_wdata;
            qtr_pkg::CSR_TURN_MODE: mode_ff <= csr_wdata[qtr_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (push) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_comb begin
      eff_r = eff_dim(rows_ff);
      eff_c = eff_dim(cols_ff);
      // a counter past a shrunken bound restarts at zero
      r_eff = (DW'(row_ff) >= eff_r) ? '0 : row_ff;
      c_eff = (DW'(col_ff) >= eff_c) ? '0 : col_ff;
      r_rev_w = eff_r - DW'(r_eff) - DW'(1);
      c_rev_w = eff_c - DW'(c_eff) - DW'(1);
      r_rev   = r_rev_w[CW-1:0];
      c_rev   = c_rev_w[CW-1:0];
      last_r  = (DW'(r_eff) == eff_r - DW'(1));
      last_c  = (DW'(c_eff) == eff_c - DW'(1));

      if (last_c) begin
         col_in = '0;
         row_in = last_r ? '0 : CW'(r_eff + CW'(1));
      end else begin
         col_in = CW'(c_eff + CW'(1));
         row_in = r_eff;
      end

      info.pixel = src_pixel;
      info.last  = last_r && last_c;
      unique case (mode_ff)
         qtr_pkg::TURN_NONE: begin
            op_a = r_eff;  op_m = eff_c;  op_b = c_eff;
            info.rows = qtr_pkg::DIM_W'(eff_r);
            info.cols = qtr_pkg::DIM_W'(eff_c);
         end
         qtr_pkg::TURN_90: begin
            op_a = c_rev;  op_m = eff_r;  op_b = r_eff;
            info.rows = qtr_pkg::DIM_W'(eff_c);
            info.cols = qtr_pkg::DIM_W'(eff_r);
         end
         qtr_pkg::TURN_180: begin
            op_a = r_rev;  op_m = eff_c;  op_b = c_rev;
            info.rows = qtr_pkg::DIM_W'(eff_r);
            info.cols = qtr_pkg::DIM_W'(eff_c);
         end
         default: begin
            op_a = c_eff;  op_m = eff_r;  op_b = r_rev;
            info.rows = qtr_pkg::DIM_W'(eff_c);
            info.cols = qtr_pkg::DIM_W'(eff_r);
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/qtr_fifo.sv
// small first-in first-out queue between front and back
`default_nettype none

module qtr_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   input  wire [W-1:0]                    wdata,
   input  wire                            pop,
   output logic [W-1:0]                   rdata,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     level
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH+1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      level_in  = level_ff + LW'(push) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign full  = (level_ff == LW'(DEPTH));
   assign empty = (level_ff == '0);
   assign level = level_ff;

endmodule

`default_nettype wire

FILE: sv/qtr_back.sv
// back end: multiply-add of the index and the registered result stage
`default_nettype none

module qtr_back #(
   parameter int CW = 12,
   parameter int DW = 13
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  qtr_pkg::info_type   info,
   input  wire [CW-1:0]        op_a,
   input  wire [DW-1:0]        op_m,
   input  wire [CW-1:0]        op_b,
   output logic                pop,
   qtr_rsp_if.source           rsp
);

   localparam int PW = CW + DW;
   localparam int SW = PW + 1;
   localparam int IW = qtr_pkg::INDEX_W;

   logic [PW-1:0] prod;
   logic [SW-1:0] sum;

   logic                        valid_ff;
   logic [qtr_pkg::PIXEL_W-1:0] pixel_ff;
   logic [IW-1:0]               index_ff, index_in;
   logic [qtr_pkg::DIM_W-1:0]   rows_ff;
   logic [qtr_pkg::DIM_W-1:0]   cols_ff;
   logic                        last_ff;

   always_comb begin
      prod     = PW'(op_a) * PW'(op_m);
      sum      = SW'(prod) + SW'(op_b);
      index_in = IW'(sum);
      pop      = head_valid && (!valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff <= info.pixel;
         index_ff <= index_in;
         rows_ff  <= info.rows;
         cols_ff  <= info.cols;
         last_ff  <= info.last;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.dst_pixel  = pixel_ff;
   assign rsp.dst_index  = index_ff;
   assign rsp.dst_rows   = rows_ff;
   assign rsp.dst_cols   = cols_ff;
   assign rsp.frame_last = last_ff;

endmodule

`default_nettype wire

FILE: sv/quarter_turn_rotate_addr.sv
// top level of the quarter-turn rotate address generator
`default_nettype none

//  channel   dir   handshake        payload
//  req_bus   in    valid / ready    src_pixel
//  rsp_bus   out   valid / ready    dst_pixel dst_index dst_rows dst_cols frame_last
//  csr_*     in    csr_we only      csr_index csr_wdata
//
//  one pixel per clock sustained while rsp_bus.ready holds; a taken beat waits in the queue for the output register
//  a beat passes through the two-entry queue write and then the output register after the multiply
//  synchronous reset clears counters, registers to rows 1 cols 1 mode 0, and empties the queue
//  req_bus.ready drops only when the queue is full, so a stalled output absorbs two more beats
//  the output register stays loaded until rsp_bus.ready takes it

module quarter_turn_rotate_addr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_we,
   input  wire [qtr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [qtr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   qtr_req_if.sink                         req_bus,
   qtr_rsp_if.source                       rsp_bus
);

   // counter width holds MAX_DIM-1, dimension width holds MAX_DIM
   localparam int CW      = (qtr_pkg::MAX_DIM > 2) ? $clog2(qtr_pkg::MAX_DIM) : 1;
   localparam int DW      = $clog2(qtr_pkg::MAX_DIM + 1);
   localparam int Q_DEPTH = 2;
   localparam int LW      = $clog2(Q_DEPTH + 1);
   localparam int QW      = $bits(qtr_pkg::info_type) + CW + DW + CW;

   // front side
   qtr_pkg::info_type f_info;
   logic [CW-1:0]     f_op_a, f_op_b;
   logic [DW-1:0]     f_op_m;

   // queue
   logic          q_push, q_pop, q_full, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;
   logic [LW-1:0] q_level;

   // back side
   qtr_pkg::info_type b_info;
   logic [CW-1:0]     b_op_a, b_op_b;
   logic [DW-1:0]     b_op_m;

   // a beat is taken whenever there is room in the queue
   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;

   qtr_front #(
      .CW      (CW),
      .DW      (DW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (q_push),
      .src_pixel (req_bus.src_pixel),
      .info      (f_info),
      .op_a      (f_op_a),
      .op_m      (f_op_m),
      .op_b      (f_op_b)
   );

   assign q_wdata = {f_info, f_op_a, f_op_m, f_op_b};

   qtr_fifo #(
      .W     (QW),
      .DEPTH (Q_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty),
      .level (q_level)
   );

   assign {b_info, b_op_a, b_op_m, b_op_b} = q_rdata;

   qtr_back #(
      .CW (CW),
      .DW (DW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .info       (b_info),
      .op_a       (b_op_a),
      .op_m       (b_op_m),
      .op_b       (b_op_b),
      .pop        (q_pop),
      .rsp        (rsp_bus)
   );

   // reset leaves nothing in flight
   ap_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_bus.valid && q_level == '0))
      else $error("beat in flight right after reset");

   // queue fill tracks accepted and forwarded beats
   ap_level_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         (q_level == $past(q_level) + LW'($past(q_push)) - LW'($past(q_pop))))
      else $error("queue level out of step with push and pop");

   // back end never pulls from an empty queue
   ap_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_level != '0))
      else $error("pop from empty queue");

   // a held output beat blocks the back end
   ap_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !q_pop)
      else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
